[design/range_max_segment_tree_top_macros.svh]
// Assertion macros shared by the range-maximum tree RTL.
// Included by every file that carries concurrent assertions; needs clk and arst_n in scope.
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RMST_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define RMST_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RMST_ASSERT_ALWAYS(label, cond, msg)
`define RMST_ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

[design/rmst_pkg.sv]
// Types, codes and helpers for the range-maximum tree.
// No dependencies; used by the engine, the output stage and the top level.
package rmst_pkg;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic signed [31:0] EMPTY_MAX = -32'sd1000000000;

	typedef struct packed {
		logic               func;
		logic [9:0]         position;
		logic signed [31:0] value;
		logic [9:0]         range_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] max_value;
		logic               empty_range;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_push_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_UP,
		ST_QRY,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic signed [31:0] smax(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

[design/rmst_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is set where the channel is instantiated.
interface rmst_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[design/rmst_engine.sv]
// Tree store and walker: node memory, clearing pass, leaf update and range query.
// Depends on rmst_pkg, rmst_stream_if and the assertion macro header.
`include "range_max_segment_tree_top_macros.svh"

module rmst_engine #(
	parameter int unsigned LEAF_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	rmst_stream_if.sink        request,
	output rmst_pkg::res_push_t push,
	input  logic               push_ready
);
	import rmst_pkg::*;

	localparam int unsigned NODES = 2 * LEAF_COUNT;
	localparam int unsigned AW = $clog2(NODES);
	localparam logic [31:0] LEAF_W = 32'(LEAF_COUNT);
	localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
	localparam logic [AW-1:0] ROOT_NODE = AW'(1);

	state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      idx_a_q, idx_b_q;
	logic signed [31:0] val_q, acc_q;
	logic               empty_q;

	logic signed [31:0] tree_mem_q [NODES];
	logic signed [31:0] rdata_a_s1, rdata_b_s1;
	logic               rd_vld_s1;
	logic signed [31:0] pair_s2;
	logic               pair_vld_s2;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_ren_a, mem_ren_b;
	logic [AW-1:0]      mem_raddr_a, mem_raddr_b;

	logic [31:0]        pos_w, end_w, end_clamp;
	logic               accept, is_query, wr_inside, q_empty;
	logic [AW:0]        s_inc;
	logic [AW-1:0]      s_nx, e_nx, k_up;
	logic               q_more;
	logic signed [31:0] parent;

	assign pos_w     = 32'(request.payload.position);
	assign end_w     = 32'(request.payload.range_end);
	assign end_clamp = (end_w >= LEAF_W) ? (LEAF_W - 32'd1) : end_w;
	assign is_query  = (request.payload.func == FUNC_QUERY);
	assign wr_inside = (pos_w < LEAF_W);
	assign q_empty   = (pos_w > end_clamp);
	assign accept    = request.valid && request.ready;

	// start climbs as (s+1)>>1, end as (e-1)>>1; e stays >= 1 inside the walk
	assign s_inc  = ({1'b0, idx_a_q} + {{AW{1'b0}}, 1'b1}) >> 1;
	assign s_nx   = s_inc[AW-1:0];
	assign e_nx   = (idx_b_q - ROOT_NODE) >> 1;
	assign q_more = (s_nx <= e_nx);

	// write walk: parent is the running value against the sibling just read
	assign k_up   = idx_a_q >> 1;
	assign parent = smax(val_q, rdata_a_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == LAST_NODE) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (is_query) state_d = q_empty ? ST_DONE : ST_QRY;
					else if (wr_inside) state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_UP;
			ST_UP: if (k_up == ROOT_NODE) state_d = ST_IDLE;
			ST_QRY: if (!q_more) state_d = ST_DRAIN;
			ST_DRAIN: if (!rd_vld_s1 && !pair_vld_s2) state_d = ST_DONE;
			ST_DONE: if (push_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		request.ready = 1'b0;
		push.valid    = 1'b0;
		push.item     = '{max_value: acc_q, empty_range: empty_q};
		mem_we        = 1'b0;
		mem_waddr     = idx_a_q;
		mem_wdata     = val_q;
		mem_ren_a     = 1'b0;
		mem_ren_b     = 1'b0;
		mem_raddr_a   = idx_a_q;
		mem_raddr_b   = idx_b_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: request.ready = 1'b1;
			ST_WRITE: begin
				mem_we      = 1'b1;
				mem_ren_a   = 1'b1;
				mem_raddr_a = idx_a_q ^ ROOT_NODE;
			end
			ST_UP: begin
				mem_we      = 1'b1;
				mem_waddr   = k_up;
				mem_wdata   = parent;
				mem_ren_a   = (k_up != ROOT_NODE);
				mem_raddr_a = k_up ^ ROOT_NODE;
			end
			ST_QRY: begin
				mem_ren_a = 1'b1;
				mem_ren_b = 1'b1;
			end
			ST_DRAIN: ;
			ST_DONE: push.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			pair_vld_s2 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_vld_s1   <= mem_ren_b;
			pair_vld_s2 <= rd_vld_s1;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ROOT_NODE;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_a_q <= AW'(pos_w + LEAF_W);
					idx_b_q <= AW'(end_clamp + LEAF_W);
					val_q   <= request.payload.value;
					acc_q   <= EMPTY_MAX;
					empty_q <= q_empty;
				end
			end
			ST_UP: begin
				idx_a_q <= k_up;
				val_q   <= parent;
			end
			ST_QRY: begin
				idx_a_q <= s_nx;
				idx_b_q <= e_nx;
			end
			default: ;
		endcase
		pair_s2 <= smax(rdata_a_s1, rdata_b_s1);
		if (pair_vld_s2) acc_q <= smax(acc_q, pair_s2);
	end

	always_ff @(posedge clk) begin
		if (mem_we) tree_mem_q[mem_waddr] <= mem_wdata;
		if (mem_ren_a) rdata_a_s1 <= tree_mem_q[mem_raddr_a];
		if (mem_ren_b) rdata_b_s1 <= tree_mem_q[mem_raddr_b];
	end

	`RMST_ASSERT_IMPLIES(a_no_rw_collision, mem_we && mem_ren_a, mem_waddr != mem_raddr_a, "read and write hit the same node")
	`RMST_ASSERT_IMPLIES(a_query_order, state_q == ST_QRY, idx_a_q <= idx_b_q, "query walk past its end")
	`RMST_ASSERT_IMPLIES(a_done_drained, state_q == ST_DONE, !rd_vld_s1 && !pair_vld_s2, "result offered before reduction drained")
	`RMST_ASSERT_ALWAYS(a_empty_value, !(push.valid && push.item.empty_range) || (push.item.max_value == EMPTY_MAX), "empty result with wrong value")

endmodule

[design/rmst_out_reg.sv]
// Output register between the engine and the result channel.
// Depends on rmst_pkg and rmst_stream_if.
module rmst_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  rmst_pkg::res_push_t push,
	output logic                push_ready,
	rmst_stream_if.source       response
);
	import rmst_pkg::*;

	logic      full_q;
	out_item_t data_q;

	// a held result may leave in the same cycle a new one is loaded
	assign push_ready       = !full_q || response.ready;
	assign response.valid   = full_q;
	assign response.payload = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push.valid && push_ready) begin
			full_q <= 1'b1;
		end else if (response.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ready) data_q <= push.item;
	end

endmodule

[design/range_max_segment_tree_top.sv]
// Top level of the range-maximum tree: walker with node memory plus output register.
// Depends on rmst_pkg, rmst_stream_if, rmst_engine and rmst_out_reg.
//
//  channel   dir  payload                                   per transaction
//  request   in   func, position, value, range_end          write leaf or query range
//  response  out  max_value, empty_range                    one per query, none per write
//
// A write runs accept, leaf store, then the ancestors one at a time up to the root, an order
// set by the single write port of the node memory; a write past the last leaf is dropped.
// A query runs accept, one memory read pair per level, then a drain of the read and
// reduction registers; an empty range goes straight from accept to its result.
// After reset the node memory is zeroed one entry per cycle, all 2*LEAF_COUNT entries,
// with request.ready low.
// One item is in work at a time; a finished result waits in the output register while
// the next request is taken.
module range_max_segment_tree_top #(
	parameter int unsigned LEAF_COUNT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	rmst_stream_if.sink   request,
	rmst_stream_if.source response
);
	import rmst_pkg::*;

	res_push_t push;
	logic      push_ready;

	rmst_engine #(
		.LEAF_COUNT(LEAF_COUNT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.push       (push),
		.push_ready (push_ready)
	);

	rmst_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.response   (response)
	);

endmodule

[tb/range_max_segment_tree_top_test.sv]
// Self-checking bench for the range-maximum tree: writes leaves, queries ranges, checks maxima.
// Depends on rmst_pkg, rmst_stream_if and range_max_segment_tree_top; the expected maxima come
// from a tree kept in a small scoreboard class.
module range_max_segment_tree_top_test;
	import rmst_pkg::*;

	localparam int unsigned LEAVES       = 1024;
	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned IDLE_LIMIT   = 20000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned TAIL_CYCLES  = 40;

	// Shadow tree plus the queue of query answers still owed by the block.
	class max_tree_board;
		logic signed [31:0] node [0:2*LEAVES-1];
		out_item_t          owed_max [$];
		int unsigned        mismatches;
		int unsigned        checked;

		function new();
			foreach (node[k]) node[k] = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function logic signed [31:0] larger(logic signed [31:0] a, logic signed [31:0] b);
			return (a > b) ? a : b;
		endfunction

		function void note_request(in_item_t it);
			int unsigned k;
			int unsigned s;
			int unsigned e;
			out_item_t r;
			if (it.func == FUNC_WRITE) begin
				if (it.position < LEAVES) begin
					k = 32'(it.position) + LEAVES;
					node[k] = it.value;
					while (k > 1) begin
						k = k >> 1;
						node[k] = larger(node[2*k], node[2*k+1]);
					end
				end
				return;
			end
			e = 32'(it.range_end);
			if (e >= LEAVES) e = LEAVES - 1;
			s = 32'(it.position);
			r.max_value = EMPTY_MAX;
			r.empty_range = 1'b0;
			if (s > e) begin
				r.empty_range = 1'b1;
			end else begin
				s = s + LEAVES;
				e = e + LEAVES;
				// both boundary nodes are taken at every level; max does not mind doubles
				while (s <= e) begin
					r.max_value = larger(r.max_value, larger(node[s], node[e]));
					s = (s + 1) >> 1;
					e = (e - 1) >> 1;
				end
			end
			owed_max = {owed_max, r};
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			checked++;
			if (owed_max.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: max %0d empty %0b",
						got.max_value, got.empty_range);
				return;
			end
			want = owed_max.pop_front();
			if (got.max_value !== want.max_value || got.empty_range !== want.empty_range) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected max %0d empty %0b, got max %0d empty %0b",
						want.max_value, want.empty_range, got.max_value, got.empty_range);
			end
		endfunction

		function int unsigned outstanding();
			return owed_max.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rmst_stream_if #(.item_t(in_item_t))  request_ch ();
	rmst_stream_if #(.item_t(out_item_t)) response_ch ();

	range_max_segment_tree_top #(.LEAF_COUNT(LEAVES)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.response(response_ch)
	);

	max_tree_board board = new();
	in_item_t      stim_q [$];
	int unsigned   idle_cycles;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic in_item_t leaf_write(int unsigned pos, logic signed [31:0] val);
		in_item_t it;
		it.func = FUNC_WRITE;
		it.position = pos[9:0];
		it.value = val;
		it.range_end = 10'($urandom);
		return it;
	endfunction

	function automatic in_item_t range_query(int unsigned first, int unsigned last);
		in_item_t it;
		it.func = FUNC_QUERY;
		it.position = first[9:0];
		it.value = $urandom;
		it.range_end = last[9:0];
		return it;
	endfunction

	function automatic void queue_stim(in_item_t it);
		stim_q = {stim_q, it};
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 200) - 100;
			1: begin
				case ($urandom_range(0, 2))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t pick_item();
		int unsigned a;
		int unsigned b;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) return leaf_write($urandom_range(0, LEAVES - 1), pick_value());
		if (sel < 48) begin
			b = $urandom_range(0, LEAVES - 2);
			return range_query($urandom_range(b + 1, LEAVES - 1), b);
		end
		if (sel < 75) begin
			a = $urandom_range(0, LEAVES - 1);
			b = a + $urandom_range(0, 16);
			if (b > LEAVES - 1) b = LEAVES - 1;
			return range_query(a, b);
		end
		if (sel < 95) begin
			a = $urandom_range(0, LEAVES - 1);
			b = $urandom_range(0, LEAVES - 1);
			return (a <= b) ? range_query(a, b) : range_query(b, a);
		end
		// prefix or suffix spans
		if ($urandom_range(0, 1)) return range_query(0, $urandom_range(0, LEAVES - 1));
		return range_query($urandom_range(0, LEAVES - 1), LEAVES - 1);
	endfunction

	task automatic put_request(in_item_t it);
		request_ch.valid <= 1'b1;
		request_ch.payload <= it;
		do @(posedge clk); while (!request_ch.ready);
		board.note_request(it);
	endtask

	task automatic hold_requests(int unsigned n);
		request_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// response acceptance and the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n && response_ch.valid && response_ch.ready)
			board.check_response(response_ch.payload);
		if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver backpressure: stretches of different stall patterns, one long hold-off
	initial begin
		int unsigned mode;
		int unsigned span;
		bit          held;
		held = 1'b0;
		response_ch.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (int unsigned c = 0; c < span; c++) begin
				@(posedge clk);
				if (!held && board.checked >= 120) begin
					held = 1'b1;
					response_ch.ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: response_ch.ready <= 1'b1;
					1: response_ch.ready <= 1'($urandom_range(0, 1));
					2: response_ch.ready <= ($urandom_range(0, 3) == 0);
					default: response_ch.ready <= (c % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		int unsigned burst_left;
		int unsigned gap;
		in_item_t    it;
		idle_cycles = 0;
		arst_n <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.payload <= '0;

		// zero tree, empty ranges, extreme values and positions, ignored fields
		queue_stim(range_query(0, LEAVES - 1));
		queue_stim(range_query(5, 3));
		queue_stim(range_query(LEAVES - 1, 0));
		queue_stim(range_query(1, 0));
		queue_stim(leaf_write(0, 32'sh8000_0000));
		queue_stim(range_query(0, 0));
		queue_stim(leaf_write(LEAVES - 1, 32'sh7fff_ffff));
		queue_stim(range_query(LEAVES - 1, LEAVES - 1));
		queue_stim(range_query(0, LEAVES - 1));
		queue_stim(range_query(1, LEAVES - 2));
		it = leaf_write(512, -32'sd5);
		it.range_end = 10'h3ff;
		queue_stim(it);
		it = range_query(512, 512);
		it.value = 32'sh7fff_ffff;
		queue_stim(it);
		queue_stim(leaf_write(LEAVES - 1, -32'sd1));
		queue_stim(range_query(0, LEAVES - 1));
		queue_stim(leaf_write(511, 32'sd1000));
		queue_stim(range_query(511, 512));
		queue_stim(range_query(0, 511));
		queue_stim(range_query(512, LEAVES - 1));
		queue_stim(leaf_write(1, EMPTY_MAX));
		queue_stim(range_query(0, 1));
		it = leaf_write(LEAVES - 1, -32'sd1);
		it.range_end = 10'h3ff;
		queue_stim(it);
		queue_stim(range_query(LEAVES - 2, LEAVES - 1));
		queue_stim(range_query(LEAVES - 1, LEAVES - 2));
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) queue_stim(pick_item());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		burst_left = 0;
		for (int unsigned n = 0; n < stim_q.size(); n++) begin
			if (n == 360) begin
				// let the block run dry before continuing
				hold_requests(1);
				while (board.outstanding() > 0) @(posedge clk);
			end
			if (burst_left == 0) begin
				if ($urandom_range(0, 5) == 0) begin
					gap = 0;
					burst_left = 60;
				end else begin
					gap = $urandom_range(0, 12);
					burst_left = $urandom_range(1, 24);
				end
				if (gap > 0) hold_requests(gap);
			end
			put_request(stim_q[n]);
			burst_left--;
		end
		hold_requests(1);

		while (board.outstanding() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[range_max_segment_tree_top.f]
+incdir+design
design/rmst_pkg.sv
design/rmst_stream_if.sv
design/rmst_engine.sv
design/rmst_out_reg.sv
design/range_max_segment_tree_top.sv
tb/range_max_segment_tree_top_test.sv
